>>> rtl/core/swfd_pkg.sv
// Shared constants and the result and status types of the sync-word frame deframer.
`default_nettype none

package swfd_pkg;

  // Frame geometry.
  localparam int unsigned FrameLen   = 14;
  localparam int unsigned OffsetBits = 4;

  localparam logic [OffsetBits-1:0] LAST_OFFSET = 4'd13;
  localparam logic [OffsetBits-1:0] FIRST_OFFSET = 4'd0;

  // Sync word A0 B8 21 0A and trailer 59 A6.
  localparam logic [23:0] SYNC_PREFIX = 24'hA0B821;
  localparam logic [7:0]  SYNC_LAST   = 8'h0A;
  localparam logic [7:0]  TRAIL_FIRST = 8'h59;
  localparam logic [7:0]  TRAIL_LAST  = 8'hA6;

  // Decoded fields of one accepted frame.
  typedef struct packed {
    logic signed [31:0] motor_one_position;
    logic signed [15:0] motor_one_current;
    logic signed [15:0] motor_two_position;
    logic signed [15:0] motor_three_position;
  } swfd_result_t;

  // Status from the frame tracker to the top level.
  typedef struct packed {
    logic at_last;
    logic res_valid;
  } swfd_status_t;

endpackage

`default_nettype wire

>>> rtl/core/swfd_tracker.sv
// Frame tracker: sync search, frame store, trailer check and field decode.
`default_nettype none

module swfd_tracker (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  step,
  input  wire logic [7:0]            byte_in,
  output swfd_pkg::swfd_status_t     status,
  output swfd_pkg::swfd_result_t     result
);
  import swfd_pkg::*;

  logic [23:0]           recent_bytes;
  logic                  in_frame;
  logic [OffsetBits-1:0] frame_offset;
  logic [7:0]            frame_store [FrameLen];

  logic                  sync_hit;
  logic                  eff_in_frame;
  logic [OffsetBits-1:0] eff_offset;
  logic                  last_beat;

  // A full sync word restarts the frame with the current byte at offset zero.
  always_comb begin
    sync_hit     = (recent_bytes == SYNC_PREFIX) && (byte_in == SYNC_LAST);
    eff_in_frame = sync_hit || in_frame;
    if (sync_hit) begin
      eff_offset = FIRST_OFFSET;
    end else if (frame_offset > LAST_OFFSET) begin
      eff_offset = LAST_OFFSET;
    end else begin
      eff_offset = frame_offset;
    end
    last_beat = eff_in_frame && (eff_offset == LAST_OFFSET);
  end

  // Offset thirteen is the current byte; offset twelve is already stored.
  assign status.at_last   = in_frame && (frame_offset == LAST_OFFSET);
  assign status.res_valid = step && last_beat && (frame_store[12] == TRAIL_FIRST) &&
                            (byte_in == TRAIL_LAST);

  // Big-endian fields from the stored bytes.
  assign result.motor_one_position   = {frame_store[2], frame_store[3],
                                        frame_store[4], frame_store[5]};
  assign result.motor_one_current    = {frame_store[6], frame_store[7]};
  assign result.motor_two_position   = {frame_store[8], frame_store[9]};
  assign result.motor_three_position = {frame_store[10], frame_store[11]};

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      recent_bytes <= '0;
      in_frame     <= 1'b0;
      frame_offset <= FIRST_OFFSET;
    end else if (step) begin
      recent_bytes <= {recent_bytes[15:0], byte_in};
      if (eff_in_frame) begin
        if (last_beat) begin
          in_frame     <= 1'b0;
          frame_offset <= FIRST_OFFSET;
        end else begin
          in_frame     <= 1'b1;
          frame_offset <= eff_offset + 1'b1;
        end
      end
    end
  end

  // Frame store; the entries need no reset.
  always_ff @(posedge clk) begin
    if (step && eff_in_frame) begin
      frame_store[eff_offset] <= byte_in;
    end
  end

`ifndef SYNTHESIS
  // The offset never runs past the last frame byte.
  assert property (@(posedge clk) disable iff (rst) frame_offset <= LAST_OFFSET)
    else $error("frame offset out of range");

  // Outside a frame the offset rests at zero.
  assert property (@(posedge clk) disable iff (rst) !in_frame |-> frame_offset == FIRST_OFFSET)
    else $error("offset not cleared outside a frame");

  // After a good frame the tracker leaves the frame.
  assert property (@(posedge clk) disable iff (rst) status.res_valid |=> !in_frame)
    else $error("still in frame after a result");
`endif

endmodule

`default_nettype wire

>>> rtl/core/sync_word_frame_deframer_top.sv
// Top level of the sync-word frame deframer: input register, tracker and result register.
//
// Usage:
//   Input channel: rx_byte with in_valid / in_ready; one received byte per beat.
//   Output channel: motor_one_position, motor_one_current, motor_two_position and
//   motor_three_position with out_valid / out_ready; one beat per frame that has
//   the sync word A0 B8 21 0A and the trailer 59 A6.
//   A byte beat lands in the input register; when it moves on, it runs through
//   the tracker, and a good frame's last byte loads the decoded frame into the
//   result register, which drives the output.
//   Unstalled throughput is one byte per cycle, set by one tracker update per edge.
//   When the receiver stalls, bytes keep flowing until a byte at the last frame
//   offset would need the still-occupied result register; only then in_ready
//   drops, until out_ready takes the waiting result.
//   Reset (rst, synchronous) empties both registers and drops any partial frame.
`default_nettype none

module sync_word_frame_deframer_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         rx_byte,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      motor_one_position,
  output logic signed [15:0]      motor_one_current,
  output logic signed [15:0]      motor_two_position,
  output logic signed [15:0]      motor_three_position
);
  import swfd_pkg::*;

  logic         s1_valid;
  logic [7:0]   s1_byte;
  logic         s1_advance;
  logic         step;
  swfd_status_t status;
  swfd_result_t result;

  // The held byte moves on unless it ends a frame while the result register is full.
  assign s1_advance = !(out_valid && !out_ready && status.at_last);
  assign step       = s1_valid && s1_advance;
  assign in_ready   = !s1_valid || s1_advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte <= rx_byte;
    end
  end

  swfd_tracker u_tracker (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .byte_in (s1_byte),
    .status  (status),
    .result  (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (status.res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (status.res_valid) begin
      motor_one_position   <= result.motor_one_position;
      motor_one_current    <= result.motor_one_current;
      motor_two_position   <= result.motor_two_position;
      motor_three_position <= result.motor_three_position;
    end
  end

`ifndef SYNTHESIS
  // A new result never overwrites one still waiting.
  assert property (@(posedge clk) disable iff (rst)
    status.res_valid |-> !(out_valid && !out_ready))
    else $error("result register overwritten");

  // The held byte only waits behind a stalled result.
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_advance) |-> (out_valid && !out_ready))
    else $error("input stalled without cause");

  // A byte that produces a result has gone through the input register.
  assert property (@(posedge clk) disable iff (rst) status.res_valid |-> s1_valid)
    else $error("result without an input byte");
`endif

endmodule

`default_nettype wire
